// ===== hdl/minmax_contrast_stretch_defines.svh =====
// Assertion macros shared by the contrast stretch RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef MINMAX_CONTRAST_STRETCH_DEFINES_SVH
`define MINMAX_CONTRAST_STRETCH_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define MCS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define MCS_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hdl/mcs_pkg.sv =====
// Package for the min-max contrast stretch: request and response types,
// status codes, state encoding and sizing constants. Depends on nothing.
package mcs_pkg;

   localparam int unsigned MAX_PIXELS_DEF = 4096;
   localparam int COMP_W = 16;
   localparam int OUT_W = 8;
   localparam int DIV_STEPS = 8;
   localparam int STEP_W = $clog2(DIV_STEPS);
   localparam logic [COMP_W-1:0] MIN_INIT = '1;
   localparam logic [COMP_W-1:0] MAX_INIT = '0;

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_FETCH = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_DROPPED = 2'd2
   } status_type;

   typedef struct packed {
      func_type          func;
      logic [COMP_W-1:0] red_in;
      logic [COMP_W-1:0] green_in;
      logic [COMP_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] red_out;
      logic [OUT_W-1:0] green_out;
      logic [OUT_W-1:0] blue_out;
      logic             last_out;
      status_type       status;
   } rsp_type;

   typedef struct packed {
      logic prep;
      logic load;
      logic step;
   } div_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/mcs_div_lane.sv =====
// One color lane: offset from the minimum, scaling by 255 and a restoring
// divider that yields one quotient bit per step. Depends on mcs_pkg.
module mcs_div_lane (
   input  logic                             clock,
   input  mcs_pkg::div_ctrl_type            ctrl,
   input  logic [mcs_pkg::COMP_W-1:0]       value,
   input  logic [mcs_pkg::COMP_W-1:0]       min_value,
   input  logic [mcs_pkg::COMP_W-1:0]       span,
   output logic [mcs_pkg::OUT_W-1:0]        quotient
);

   localparam int CW = mcs_pkg::COMP_W;
   localparam int QW = mcs_pkg::OUT_W;
   localparam int PW = CW + QW;

   logic [CW-1:0] diff_ff, diff_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [QW-1:0] qsh_ff, qsh_in;
   logic [PW-1:0] prod;
   logic [CW+1:0] trial;
   logic          fits;

   // The scaled dividend is below 256 times the span, so its upper part
   // starts as a remainder smaller than the divisor. Its low byte shifts
   // out at the top of qsh_ff while quotient bits shift in at the bottom.
   always_comb begin
      diff_in = (value > min_value) ? (value - min_value) : '0;
      prod    = {diff_ff, {QW{1'b0}}} - {{QW{1'b0}}, diff_ff};
      trial   = {1'b0, rem_ff, qsh_ff[QW-1]} - {2'b00, span};
      fits    = !trial[CW+1];
      rem_in  = rem_ff;
      qsh_in  = qsh_ff;
      if (ctrl.load) begin
         rem_in = prod[PW-1:QW];
         qsh_in = prod[QW-1:0];
      end else if (ctrl.step) begin
         rem_in = fits ? trial[CW-1:0] : {rem_ff[CW-2:0], qsh_ff[QW-1]};
         qsh_in = {qsh_ff[QW-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.prep) begin
         diff_ff <= diff_in;
      end
      rem_ff <= rem_in;
      qsh_ff <= qsh_in;
   end

   assign quotient = qsh_ff;

endmodule

// ===== hdl/minmax_contrast_stretch.sv =====
// Min-max contrast stretch. A load leaves busy low.
// A fetch of a stored pixel reads the store at acceptance and then holds busy
// through an offset state, a scaling state, eight restoring divide steps and an
// output state; the strobe comes on the cycle after, and no new request is taken
// while busy. An empty fetch answers on the next cycle. Synchronous
// reset clears all control state; the pixel store is undefined until written.
`include "minmax_contrast_stretch_defines.svh"

module minmax_contrast_stretch #(
   parameter int unsigned MAX_PIXELS = mcs_pkg::MAX_PIXELS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mcs_pkg::req_type req_data,
   output logic             rsp_strobe,
   output mcs_pkg::rsp_type rsp_data
);

   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int NW = $clog2(MAX_PIXELS + 1);
   localparam int CW = mcs_pkg::COMP_W;
   localparam int QW = mcs_pkg::OUT_W;
   localparam int SW = mcs_pkg::STEP_W;
   localparam logic [SW-1:0] LAST_STEP = SW'(mcs_pkg::DIV_STEPS - 1);

   logic [3*CW-1:0] pixel_store_ff [MAX_PIXELS];
   logic [3*CW-1:0] rd_ff;

   mcs_pkg::state_type state_ff, state_in;
   logic [SW-1:0]      step_cnt_ff, step_cnt_in;
   logic [NW-1:0]      count_ff, count_in;
   logic [AW-1:0]      rp_ff, rp_in;
   logic [CW-1:0]      min_ff, min_in;
   logic [CW-1:0]      max_ff, max_in;
   logic               started_ff, started_in;
   logic               dropped_ff, dropped_in;
   logic [CW-1:0]      span_ff;
   logic               flat_ff;
   logic               last_ff;
   mcs_pkg::status_type status_ff;
   mcs_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   mcs_pkg::div_ctrl_type div_ctrl;
   logic [QW-1:0]      q_red, q_green, q_blue;

   logic               accept, is_fetch, do_store, fetch_go;
   logic [NW-1:0]      base_count;
   logic [CW-1:0]      base_min, base_max;
   logic [CW-1:0]      lo_rg, hi_rg, lo_b, hi_b;
   logic [AW-1:0]      idx;
   logic               idx_last;

   assign accept   = start && !busy;
   assign is_fetch = (req_data.func == mcs_pkg::FUNC_FETCH);
   assign fetch_go = accept && is_fetch && (count_ff != '0);

   always_comb begin
      base_count = started_ff ? '0 : count_ff;
      base_min   = started_ff ? mcs_pkg::MIN_INIT : min_ff;
      base_max   = started_ff ? mcs_pkg::MAX_INIT : max_ff;
      do_store   = accept && !is_fetch && (base_count < NW'(MAX_PIXELS));
      lo_rg = (req_data.red_in < req_data.green_in) ? req_data.red_in : req_data.green_in;
      hi_rg = (req_data.red_in > req_data.green_in) ? req_data.red_in : req_data.green_in;
      lo_b  = (req_data.blue_in < base_min) ? req_data.blue_in : base_min;
      hi_b  = (req_data.blue_in > base_max) ? req_data.blue_in : base_max;
      idx      = (NW'(rp_ff) >= count_ff) ? '0 : rp_ff;
      idx_last = (NW'(idx) == (count_ff - NW'(1)));
   end

   always_comb begin
      count_in      = count_ff;
      rp_in         = rp_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      started_in    = started_ff;
      dropped_in    = dropped_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      if (accept && !is_fetch) begin
         count_in   = base_count;
         min_in     = base_min;
         max_in     = base_max;
         rp_in      = started_ff ? '0 : rp_ff;
         dropped_in = started_ff ? 1'b0 : dropped_ff;
         started_in = 1'b0;
         if (do_store) begin
            count_in = base_count + NW'(1);
            min_in   = (lo_rg < lo_b) ? lo_rg : lo_b;
            max_in   = (hi_rg > hi_b) ? hi_rg : hi_b;
         end else begin
            dropped_in = 1'b1;
         end
      end else if (accept && is_fetch && (count_ff == '0)) begin
         rsp_in        = '{red_out: '0, green_out: '0, blue_out: '0, last_out: 1'b0,
                           status: mcs_pkg::STATUS_EMPTY};
         rsp_strobe_in = 1'b1;
      end else if (fetch_go) begin
         rp_in      = idx_last ? '0 : (idx + AW'(1));
         started_in = 1'b1;
      end
      if (state_ff == mcs_pkg::ST_DONE) begin
         rsp_in.red_out   = flat_ff ? '0 : q_red;
         rsp_in.green_out = flat_ff ? '0 : q_green;
         rsp_in.blue_out  = flat_ff ? '0 : q_blue;
         rsp_in.last_out  = last_ff;
         rsp_in.status    = status_ff;
         rsp_strobe_in    = 1'b1;
      end
   end

   always_comb begin
      state_in    = state_ff;
      step_cnt_in = step_cnt_ff;
      case (state_ff)
         mcs_pkg::ST_IDLE: begin
            if (fetch_go) begin
               state_in = mcs_pkg::ST_READ;
            end
         end
         mcs_pkg::ST_READ: begin
            state_in = mcs_pkg::ST_LOAD;
         end
         mcs_pkg::ST_LOAD: begin
            state_in    = mcs_pkg::ST_DIV;
            step_cnt_in = '0;
         end
         mcs_pkg::ST_DIV: begin
            step_cnt_in = step_cnt_ff + SW'(1);
            if (step_cnt_ff == LAST_STEP) begin
               state_in = mcs_pkg::ST_DONE;
            end
         end
         mcs_pkg::ST_DONE: begin
            state_in = mcs_pkg::ST_IDLE;
         end
         default: begin
            state_in = mcs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy          = (state_ff != mcs_pkg::ST_IDLE);
      div_ctrl.prep = (state_ff == mcs_pkg::ST_READ);
      div_ctrl.load = (state_ff == mcs_pkg::ST_LOAD);
      div_ctrl.step = (state_ff == mcs_pkg::ST_DIV);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mcs_pkg::ST_IDLE;
         step_cnt_ff   <= '0;
         count_ff      <= '0;
         rp_ff         <= '0;
         min_ff        <= mcs_pkg::MIN_INIT;
         max_ff        <= mcs_pkg::MAX_INIT;
         started_ff    <= 1'b0;
         dropped_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_cnt_ff   <= step_cnt_in;
         count_ff      <= count_in;
         rp_ff         <= rp_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         started_ff    <= started_in;
         dropped_ff    <= dropped_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (fetch_go) begin
         span_ff   <= max_ff - min_ff;
         flat_ff   <= (max_ff <= min_ff);
         last_ff   <= idx_last;
         status_ff <= dropped_ff ? mcs_pkg::STATUS_DROPPED : mcs_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (do_store) begin
         pixel_store_ff[base_count[AW-1:0]] <=
            {req_data.red_in, req_data.green_in, req_data.blue_in};
      end
      if (fetch_go) begin
         rd_ff <= pixel_store_ff[idx];
      end
   end

   mcs_div_lane u_lane_red (
      .clock     (clock),
      .ctrl      (div_ctrl),
      .value     (rd_ff[3*CW-1:2*CW]),
      .min_value (min_ff),
      .span      (span_ff),
      .quotient  (q_red)
   );

   mcs_div_lane u_lane_green (
      .clock     (clock),
      .ctrl      (div_ctrl),
      .value     (rd_ff[2*CW-1:CW]),
      .min_value (min_ff),
      .span      (span_ff),
      .quotient  (q_green)
   );

   mcs_div_lane u_lane_blue (
      .clock     (clock),
      .ctrl      (div_ctrl),
      .value     (rd_ff[CW-1:0]),
      .min_value (min_ff),
      .span      (span_ff),
      .quotient  (q_blue)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `MCS_ASSERT_NEVER(a_strobe_while_busy, clock, reset, rsp_strobe && busy, "response while busy")
   `MCS_ASSERT(a_fetch_goes_busy, clock, reset, fetch_go |=> busy, "fetch did not start")
   `MCS_ASSERT(a_count_in_range, clock, reset, count_ff <= NW'(MAX_PIXELS), "pixel count overflow")
   `MCS_ASSERT(a_result_after_div, clock, reset,
      (rsp_strobe && (rsp_data.status != mcs_pkg::STATUS_EMPTY)) |->
      ($past(state_ff) == mcs_pkg::ST_DONE), "stretched result without divide")

endmodule

// ===== test/tb_minmax_contrast_stretch.sv =====
// Self-checking testbench for minmax_contrast_stretch: loads images, fetches stretched
// pixels and compares each response with a scoreboard that models the stretch.
// Depends on mcs_pkg and the minmax_contrast_stretch RTL.
module tb_minmax_contrast_stretch;

   localparam int unsigned CAPACITY = mcs_pkg::MAX_PIXELS_DEF;

   typedef enum int {
      SPREAD_FULL,
      SPREAD_NARROW,
      SPREAD_FLAT,
      SPREAD_EDGES
   } spread_type;

   class stretch_scoreboard_type;
      mcs_pkg::rsp_type pending[$];
      mcs_pkg::req_type frame[CAPACITY];
      int unsigned lo_level;
      int unsigned hi_level;
      int unsigned stored;
      int unsigned next_idx;
      bit reading;
      bit overflowed;
      int unsigned mismatches;

      function new();
         mismatches = 0;
         begin_image();
      endfunction

      function void begin_image();
         lo_level = 65535;
         hi_level = 0;
         stored = 0;
         next_idx = 0;
         reading = 0;
         overflowed = 0;
      endfunction

      function void widen_range(logic [mcs_pkg::COMP_W-1:0] v);
         if (v > hi_level) hi_level = v;
         if (v < lo_level) lo_level = v;
      endfunction

      function logic [mcs_pkg::OUT_W-1:0] scale_component(logic [mcs_pkg::COMP_W-1:0] v);
         int unsigned q;
         if (hi_level <= lo_level || v <= lo_level) return '0;
         q = ((32'(v) - lo_level) * 255) / (hi_level - lo_level);
         return (q > 255) ? 8'd255 : q[mcs_pkg::OUT_W-1:0];
      endfunction

      function void note_request(mcs_pkg::req_type r);
         mcs_pkg::rsp_type want;
         mcs_pkg::req_type px;
         if (r.func == mcs_pkg::FUNC_LOAD) begin
            if (reading) begin_image();
            if (stored >= CAPACITY) begin
               overflowed = 1;
               return;
            end
            frame[stored] = r;
            stored++;
            widen_range(r.red_in);
            widen_range(r.green_in);
            widen_range(r.blue_in);
            return;
         end
         want = '0;
         if (stored == 0) begin
            want.status = mcs_pkg::STATUS_EMPTY;
            pending.push_back(want);
            return;
         end
         if (next_idx >= stored) next_idx = 0;
         px = frame[next_idx];
         want.red_out = scale_component(px.red_in);
         want.green_out = scale_component(px.green_in);
         want.blue_out = scale_component(px.blue_in);
         want.last_out = (next_idx == stored - 1);
         want.status = overflowed ? mcs_pkg::STATUS_DROPPED : mcs_pkg::STATUS_OK;
         next_idx = want.last_out ? 0 : next_idx + 1;
         reading = 1;
         pending.push_back(want);
      endfunction

      function void check_response(mcs_pkg::rsp_type got);
         mcs_pkg::rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: r=%0d g=%0d b=%0d last=%0d status=%0d",
                        got.red_out, got.green_out, got.blue_out, got.last_out, got.status);
            return;
         end
         want = pending.pop_front();
         if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
             got.blue_out !== want.blue_out || got.last_out !== want.last_out ||
             got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("mismatch at %0t: expected r=%0d g=%0d b=%0d last=%0d status=%0d",
                      $time, want.red_out, want.green_out, want.blue_out, want.last_out,
                      want.status);
               $display(", got r=%0d g=%0d b=%0d last=%0d status=%0d",
                        got.red_out, got.green_out, got.blue_out, got.last_out,
                        got.status);
            end
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   mcs_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   mcs_pkg::rsp_type rsp_data;

   stretch_scoreboard_type sb;
   int idle_pct = 0;

   minmax_contrast_stretch #(.MAX_PIXELS(CAPACITY)) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe && sb != null) sb.check_response(rsp_data);
   end

   task automatic send_request(mcs_pkg::func_type f, logic [mcs_pkg::COMP_W-1:0] r,
                               logic [mcs_pkg::COMP_W-1:0] g,
                               logic [mcs_pkg::COMP_W-1:0] b);
      mcs_pkg::req_type item;
      item.func = f;
      item.red_in = r;
      item.green_in = g;
      item.blue_in = b;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(item);
   endtask

   task automatic load_pixel(logic [mcs_pkg::COMP_W-1:0] r, logic [mcs_pkg::COMP_W-1:0] g,
                             logic [mcs_pkg::COMP_W-1:0] b);
      send_request(mcs_pkg::FUNC_LOAD, r, g, b);
   endtask

   task automatic fetch_pixel();
      send_request(mcs_pkg::FUNC_FETCH, 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic drain_responses();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (sb.pending.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
   endtask

   function automatic logic [mcs_pkg::COMP_W-1:0] pick_level(spread_type kind,
                                                             logic [mcs_pkg::COMP_W-1:0] base,
                                                             int unsigned spread);
      case (kind)
         SPREAD_FULL: return 16'($urandom);
         SPREAD_NARROW: return base + 16'($urandom_range(spread));
         SPREAD_FLAT: return base;
         default: begin
            case ($urandom_range(2))
               0: return 16'h0000;
               1: return 16'hFFFF;
               default: return 16'($urandom);
            endcase
         end
      endcase
   endfunction

   task automatic run_random_phase(int pct, int quota);
      int sent;
      int n;
      int m;
      spread_type kind;
      logic [mcs_pkg::COMP_W-1:0] base;
      int unsigned spread;
      idle_pct = pct;
      sent = 0;
      while (sent < quota) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         kind = spread_type'($urandom_range(3));
         base = 16'($urandom);
         spread = $urandom_range(1, 600);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) begin
               fetch_pixel();
               sent++;
            end
            load_pixel(pick_level(kind, base, spread), pick_level(kind, base, spread),
                       pick_level(kind, base, spread));
            sent++;
         end
         m = $urandom_range(n + 3);
         repeat (m) begin
            fetch_pixel();
            sent++;
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // An image shorter than the readout wraps back to its first pixel.
      fetch_pixel();
      fetch_pixel();
      load_pixel(16'h0000, 16'h0000, 16'h0000);
      load_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      load_pixel(16'h8000, 16'h00FF, 16'hFF00);
      load_pixel(16'hAAAA, 16'h5555, 16'h1234);
      repeat (5) fetch_pixel();
      load_pixel(16'h1234, 16'h1234, 16'h1234);
      load_pixel(16'h1234, 16'h1234, 16'h1234);
      repeat (2) fetch_pixel();
      load_pixel(16'd100, 16'd200, 16'd300);
      fetch_pixel();
      load_pixel(16'd7, 16'd7, 16'd9);
      repeat (2) fetch_pixel();
      drain_responses();

      run_random_phase(0, 250);
      drain_responses();
      run_random_phase(83, 250);
      drain_responses();
      run_random_phase(0, 250);
      drain_responses();
      run_random_phase(25, 250);
      drain_responses();
      repeat (24) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("minmax_contrast_stretch: match");
      else
         $display("minmax_contrast_stretch: mismatch");
      $finish;
   end

   initial begin
      #4000000;
      $display("minmax_contrast_stretch: mismatch");
      $finish;
   end

endmodule
